@@ hw/rtl/ucfh_pkg.sv @@
// ----------------------------------------------------------------------------
// ucfh_pkg
// Shared types and codes of the serial command frame handler.
// ----------------------------------------------------------------------------
package ucfh_pkg;

    localparam int PIN_COUNT_DEFAULT    = 16;
    localparam int ADC_CHANNELS_DEFAULT = 8;

    localparam int PAYLOAD_BYTES = 5;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = 1;
    localparam int QUEUE_CNT_W   = 2;

    localparam logic [7:0]  START_A         = 8'h23;
    localparam logic [7:0]  START_B         = 8'h25;
    localparam logic [7:0]  CODE_NOP        = 8'h00;
    localparam logic [7:0]  CODE_SET_PIN    = 8'h0C;
    localparam logic [7:0]  CODE_PONG       = 8'h0D;
    localparam logic [7:0]  CODE_READ_PIN   = 8'h82;
    localparam logic [7:0]  CODE_READ_ADC   = 8'h83;
    localparam logic [7:0]  CODE_PONG_REPLY = 8'h84;
    localparam logic [15:0] DIRECTION_RESET = 16'hE100;

    localparam logic OP_RX  = 1'b0;
    localparam logic OP_ADC = 1'b1;

    typedef enum logic [1:0] {
        SYNC_HUNT,
        SYNC_MARK,
        SYNC_BODY
    } sync_t;

    typedef struct packed {
        logic [PAYLOAD_BYTES-1:0][7:0] payload;
        logic [15:0]                   levels;
        logic [15:0]                   enable;
        logic [15:0]                   count;
    } reply_t;

endpackage

@@ hw/rtl/ucfh_front.sv @@
// ----------------------------------------------------------------------------
// ucfh_front
// Frame sync, checksum and command dispatch; holds pin, ADC and count state.
// ----------------------------------------------------------------------------
module ucfh_front
    import ucfh_pkg::*;
#(
    parameter int PIN_COUNT    = PIN_COUNT_DEFAULT,
    parameter int ADC_CHANNELS = ADC_CHANNELS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    input  logic [2:0]  adc_channel,
    input  logic [15:0] adc_value,
    input  logic [15:0] pin_levels,
    output logic        push,
    output reply_t      push_entry
);

    localparam int REG_W     = (PIN_COUNT > 16) ? PIN_COUNT : 16;
    localparam int PIN_IDX_W = $clog2(REG_W);
    localparam int ADC_IDX_W = (ADC_CHANNELS > 1) ? $clog2(ADC_CHANNELS) : 1;
    localparam logic [REG_W-1:0] DIR_INIT  = REG_W'(DIRECTION_RESET);
    localparam logic [2:0]       LAST_POS  = 3'(PAYLOAD_BYTES);
    localparam logic [7:0]       SUM_SEED  = 8'(START_A + START_B);

    sync_t             state_reg, state_next;
    logic [2:0]        pos_reg, pos_next;
    logic [7:0]        sum_reg, sum_next;
    logic [7:0]        store_reg [PAYLOAD_BYTES];
    logic [15:0]       adc_reg [ADC_CHANNELS];
    logic [REG_W-1:0]  level_reg, level_next;
    logic [REG_W-1:0]  dir_reg, dir_next;
    logic [15:0]       count_reg, count_next;

    logic              store_we;
    logic              frame_end;
    logic              good;
    logic              count_up;
    logic [7:0]        code;
    logic [7:0]        idx;
    logic              pin_ok;
    logic              adc_ok;
    logic [REG_W-1:0]  pin_mask;
    logic [15:0]       sample;
    logic [7:0]        ch_wide;
    logic [PAYLOAD_BYTES-1:0][7:0] p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SYNC_HUNT;
            pos_reg   <= '0;
            sum_reg   <= '0;
            level_reg <= '0;
            dir_reg   <= DIR_INIT;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            level_reg <= level_next;
            dir_reg   <= dir_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[pos_reg] <= rx_byte;
        end
    end

    assign ch_wide = {5'b0, adc_channel};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ADC_CHANNELS; i++)
            begin
                adc_reg[i] <= '0;
            end
        end
        else if (take && op == OP_ADC && 32'(adc_channel) < ADC_CHANNELS)
        begin
            adc_reg[ch_wide[ADC_IDX_W-1:0]] <= adc_value;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        store_we   = 1'b0;
        frame_end  = 1'b0;
        if (take && op == OP_RX)
        begin
            unique case (state_reg)
                SYNC_HUNT:
                begin
                    if (rx_byte == START_A)
                    begin
                        state_next = SYNC_MARK;
                    end
                end
                SYNC_MARK:
                begin
                    if (rx_byte == START_B)
                    begin
                        state_next = SYNC_BODY;
                        pos_next   = '0;
                        sum_next   = SUM_SEED;
                    end
                    else
                    begin
                        state_next = SYNC_HUNT;
                    end
                end
                SYNC_BODY:
                begin
                    if (pos_reg == LAST_POS)
                    begin
                        state_next = SYNC_HUNT;
                        pos_next   = '0;
                        frame_end  = 1'b1;
                    end
                    else
                    begin
                        store_we = 1'b1;
                        sum_next = sum_reg + rx_byte;
                        pos_next = pos_reg + 3'd1;
                    end
                end
                default:
                begin
                    state_next = SYNC_HUNT;
                end
            endcase
        end
    end

    assign code     = store_reg[0];
    assign idx      = store_reg[1];
    assign good     = frame_end && (sum_reg == rx_byte);
    assign pin_ok   = 32'(idx) < PIN_COUNT;
    assign adc_ok   = 32'(idx) < ADC_CHANNELS;
    assign pin_mask = REG_W'(1) << idx[PIN_IDX_W-1:0];
    assign sample   = adc_ok ? adc_reg[idx[ADC_IDX_W-1:0]] : 16'h0000;

    always_comb
    begin
        level_next = level_reg;
        dir_next   = dir_reg;
        push       = 1'b0;
        count_up   = 1'b0;
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            p[i] = store_reg[i];
        end
        if (good)
        begin
            unique case (code)
                CODE_NOP:
                begin
                    count_up = 1'b1;
                end
                CODE_PONG:
                begin
                    p[0]     = CODE_PONG_REPLY;
                    p[1]     = 8'h50;
                    p[2]     = 8'h4F;
                    p[3]     = 8'h4E;
                    p[4]     = 8'h47;
                    push     = 1'b1;
                    count_up = 1'b1;
                end
                CODE_SET_PIN:
                begin
                    if (pin_ok)
                    begin
                        dir_next   = dir_reg | pin_mask;
                        level_next = (store_reg[2] != 8'h00) ? (level_reg | pin_mask)
                                                             : (level_reg & ~pin_mask);
                        push       = 1'b1;
                        count_up   = 1'b1;
                    end
                end
                CODE_READ_PIN:
                begin
                    if (pin_ok)
                    begin
                        dir_next = dir_reg & ~pin_mask;
                        p[2]     = (idx < 8'd16) ? {7'b0, pin_levels[idx[3:0]]} : 8'h00;
                        p[3]     = 8'h00;
                        p[4]     = 8'h00;
                        push     = 1'b1;
                        count_up = 1'b1;
                    end
                end
                CODE_READ_ADC:
                begin
                    if (adc_ok)
                    begin
                        p[2]     = sample[7:0];
                        p[3]     = sample[15:8];
                        p[4]     = 8'h00;
                        push     = 1'b1;
                        count_up = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        count_next = count_reg + 16'(count_up);
    end

    assign push_entry.payload = p;
    assign push_entry.levels  = level_next[15:0];
    assign push_entry.enable  = dir_next[15:0];
    assign push_entry.count   = count_next;

endmodule

@@ hw/rtl/ucfh_queue.sv @@
// ----------------------------------------------------------------------------
// ucfh_queue
// Short reply queue between the dispatch front and the transmit back.
// ----------------------------------------------------------------------------
module ucfh_queue
    import ucfh_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  reply_t push_entry,
    input  logic   pop,
    output reply_t head,
    output logic   valid,
    output logic   full
);

    reply_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign valid = count_reg != '0;
    assign full  = count_reg == QUEUE_CNT_W'(QUEUE_DEPTH);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("reply queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !valid))
        else $error("reply queue underflow");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("reply queue count lost an entry");

endmodule

@@ hw/rtl/ucfh_back.sv @@
// ----------------------------------------------------------------------------
// ucfh_back
// Serialises queued replies into eight-byte frames with trailing checksum.
// ----------------------------------------------------------------------------
module ucfh_back
    import ucfh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  reply_t      q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  tx_byte,
    output logic        tx_last,
    output logic [15:0] drive_levels,
    output logic [15:0] drive_enable,
    output logic [15:0] accepted_frames
);

    localparam logic [2:0] LAST_BYTE = 3'd7;

    logic        out_valid_reg;
    logic        active_reg, active_next;
    logic [2:0]  pos_reg;
    logic [7:0]  sum_reg;
    reply_t      cur_reg;
    logic [7:0]  tx_byte_reg;
    logic        tx_last_reg;
    logic [15:0] levels_reg, enable_reg, count_reg;

    logic        step;
    logic        go;
    reply_t      entry;
    logic [2:0]  p;
    logic [7:0]  byte_sel;
    logic [7:0]  sum_base;

    always_comb
    begin
        step     = !out_valid_reg || out_ready;
        go       = step && (active_reg || q_valid);
        q_pop    = step && !active_reg && q_valid;
        entry    = active_reg ? cur_reg : q_head;
        p        = active_reg ? pos_reg : 3'd0;
        sum_base = active_reg ? sum_reg : 8'h00;
        case (p)
            3'd0:      byte_sel = START_A;
            3'd1:      byte_sel = START_B;
            LAST_BYTE: byte_sel = sum_reg;
            default:   byte_sel = entry.payload[p - 3'd2];
        endcase
        active_next = go ? (p != LAST_BYTE) : active_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            if (step)
            begin
                out_valid_reg <= go;
            end
            active_reg <= active_next;
            if (go)
            begin
                pos_reg <= p + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
        if (go)
        begin
            sum_reg     <= sum_base + byte_sel;
            tx_byte_reg <= byte_sel;
            tx_last_reg <= (p == LAST_BYTE);
            levels_reg  <= entry.levels;
            enable_reg  <= entry.enable;
            count_reg   <= entry.count;
        end
    end

    assign out_valid       = out_valid_reg;
    assign tx_byte         = tx_byte_reg;
    assign tx_last         = tx_last_reg;
    assign drive_levels    = levels_reg;
    assign drive_enable    = enable_reg;
    assign accepted_frames = count_reg;

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (go && p == LAST_BYTE) |=> !active_reg)
        else $error("frame continued past its last byte");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !active_reg)
        else $error("reply taken while a frame is in flight");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> ($stable(tx_byte_reg) && $stable(pos_reg)))
        else $error("transmit state moved during a stall");

endmodule

@@ hw/rtl/uart_command_frame_handler.sv @@
// ----------------------------------------------------------------------------
// uart_command_frame_handler
// Serial command frame handler: sync, dispatch and reply frame transmit.
// ----------------------------------------------------------------------------
// A reply passes through the reply queue and the output byte register.
// Throughput: one input item per cycle; one reply byte per cycle if out_ready.
// The two-entry reply queue sets input stall: in_ready drops while it is full.
// Reset (rst_n low, async) clears sync state, ADC samples, pin levels, the
// frame count and sets pin directions to 0xE100; the frame store is not reset.
// ----------------------------------------------------------------------------
module uart_command_frame_handler
    import ucfh_pkg::*;
#(
    parameter int PIN_COUNT    = PIN_COUNT_DEFAULT,
    parameter int ADC_CHANNELS = ADC_CHANNELS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    input  logic [2:0]  adc_channel,
    input  logic [15:0] adc_value,
    input  logic [15:0] pin_levels,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  tx_byte,
    output logic        tx_last,
    output logic [15:0] drive_levels,
    output logic [15:0] drive_enable,
    output logic [15:0] accepted_frames
);

    logic   take;
    logic   push;
    reply_t push_entry;
    logic   q_pop;
    reply_t q_head;
    logic   q_valid;
    logic   q_full;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    ucfh_front #(
        .PIN_COUNT    (PIN_COUNT),
        .ADC_CHANNELS (ADC_CHANNELS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .op          (op),
        .rx_byte     (rx_byte),
        .adc_channel (adc_channel),
        .adc_value   (adc_value),
        .pin_levels  (pin_levels),
        .push        (push),
        .push_entry  (push_entry)
    );

    ucfh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (q_head),
        .valid      (q_valid),
        .full       (q_full)
    );

    ucfh_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .tx_byte         (tx_byte),
        .tx_last         (tx_last),
        .drive_levels    (drive_levels),
        .drive_enable    (drive_enable),
        .accepted_frames (accepted_frames)
    );

endmodule

@@ tb/ucfh_reply_monitor.sv @@
// ----------------------------------------------------------------------------
// ucfh_reply_monitor
// Watches both channels of the command frame handler. It tracks the frame
// sync, ADC samples and pin registers for every accepted input item. It
// queues the reply bytes each frame should produce, and compares every
// transmitted byte with the oldest queued one, field by field.
// ----------------------------------------------------------------------------
module ucfh_reply_monitor
    import ucfh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    input  logic [2:0]  adc_channel,
    input  logic [15:0] adc_value,
    input  logic [15:0] pin_levels,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  tx_byte,
    input  logic        tx_last,
    input  logic [15:0] drive_levels,
    input  logic [15:0] drive_enable,
    input  logic [15:0] accepted_frames,
    output int          errors,
    output int          outstanding,
    output int          bytes_checked,
    output int          replies_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [15:0] levels;
        logic [15:0] enable;
        logic [15:0] count;
    } tx_beat_t;

    tx_beat_t    reply_bytes_q[$];
    sync_t       sync_st;
    int unsigned body_pos;
    logic [7:0]  frame_buf [6];
    logic [15:0] adc_mem [8];
    logic [15:0] level_q;
    logic [15:0] dir_q;
    logic [15:0] count_q;

    function automatic logic [7:0] frame_checksum(input logic [4:0][7:0] p);
        logic [7:0] chk;
        chk = START_A + START_B;
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            chk = chk + p[i];
        return chk;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        errors++;
        if (errors <= 10)
            $display("[%0t] mismatch %s: expected %0h got %0h", $realtime, what, want, got);
    endtask

    task automatic queue_reply(input logic [4:0][7:0] p);
        logic [7:0] frame [8];
        tx_beat_t   beat;
        frame[0] = START_A;
        frame[1] = START_B;
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            frame[i + 2] = p[i];
        frame[7] = frame_checksum(p);
        for (int k = 0; k < 8; k++)
        begin
            beat.data   = frame[k];
            beat.last   = (k == 7);
            beat.levels = level_q;
            beat.enable = dir_q;
            beat.count  = count_q;
            reply_bytes_q.push_back(beat);
        end
    endtask

    task automatic dispatch_frame(input logic [15:0] pins);
        logic [4:0][7:0] p;
        logic [7:0]      idx;
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            p[i] = frame_buf[i];
        if (frame_checksum(p) != frame_buf[5])
            return;
        idx = p[1];
        case (p[0])
            CODE_NOP:
            begin
                count_q++;
                return;
            end
            CODE_PONG:
            begin
                p[0] = CODE_PONG_REPLY;
                p[1] = "P";
                p[2] = "O";
                p[3] = "N";
                p[4] = "G";
            end
            CODE_SET_PIN:
            begin
                if (idx >= PIN_COUNT_DEFAULT)
                    return;
                dir_q[idx[3:0]]   = 1'b1;
                level_q[idx[3:0]] = (p[2] != 8'h00);
            end
            CODE_READ_PIN:
            begin
                if (idx >= PIN_COUNT_DEFAULT)
                    return;
                dir_q[idx[3:0]] = 1'b0;
                p[2] = {7'b0, pins[idx[3:0]]};
                p[3] = 8'h00;
                p[4] = 8'h00;
            end
            CODE_READ_ADC:
            begin
                if (idx >= ADC_CHANNELS_DEFAULT)
                    return;
                p[2] = adc_mem[idx[2:0]][7:0];
                p[3] = adc_mem[idx[2:0]][15:8];
                p[4] = 8'h00;
            end
            default:
                return;
        endcase
        count_q++;
        queue_reply(p);
    endtask

    task automatic take_item();
        if (op == OP_ADC)
        begin
            adc_mem[adc_channel] = adc_value;
            return;
        end
        case (sync_st)
            SYNC_HUNT:
                if (rx_byte == START_A)
                    sync_st = SYNC_MARK;
            SYNC_MARK:
                if (rx_byte == START_B)
                begin
                    sync_st  = SYNC_BODY;
                    body_pos = 0;
                end
                else
                    sync_st = SYNC_HUNT;
            default:
            begin
                frame_buf[body_pos] = rx_byte;
                body_pos++;
                if (body_pos >= 6)
                begin
                    sync_st  = SYNC_HUNT;
                    body_pos = 0;
                    dispatch_frame(pin_levels);
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tx_beat_t want;
        if (!rst_n)
        begin
            reply_bytes_q.delete();
            sync_st  = SYNC_HUNT;
            body_pos = 0;
            for (int i = 0; i < 8; i++)
                adc_mem[i] = 16'h0000;
            level_q         = 16'h0000;
            dir_q           = DIRECTION_RESET;
            count_q         = 16'h0000;
            outstanding     = 0;
            errors          = 0;
            bytes_checked   = 0;
            replies_checked = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                bytes_checked++;
                if (reply_bytes_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("[%0t] unexpected reply byte %0h", $realtime, tx_byte);
                end
                else
                begin
                    want = reply_bytes_q.pop_front();
                    if (tx_byte !== want.data)
                        report_mismatch("tx_byte", 16'(want.data), 16'(tx_byte));
                    if (tx_last !== want.last)
                        report_mismatch("tx_last", 16'(want.last), 16'(tx_last));
                    if (drive_levels !== want.levels)
                        report_mismatch("drive_levels", want.levels, drive_levels);
                    if (drive_enable !== want.enable)
                        report_mismatch("drive_enable", want.enable, drive_enable);
                    if (accepted_frames !== want.count)
                        report_mismatch("accepted_frames", want.count, accepted_frames);
                    if (want.last)
                        replies_checked++;
                end
            end
            if (in_valid && in_ready)
                take_item();
            outstanding = reply_bytes_q.size();
        end
    end

endmodule

@@ tb/tb_uart_command_frame_handler.sv @@
// ----------------------------------------------------------------------------
// tb_uart_command_frame_handler
// Drives serial bytes and ADC updates into the command frame handler: a
// directed set of frames and corner cases, then random traffic made mostly
// of well-formed frames. Both sides idle at random, the output is held off
// once to force input stall, and the reply monitor gives the verdict count.
// ----------------------------------------------------------------------------
module tb_uart_command_frame_handler
    import ucfh_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 360;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        op          = OP_RX;
    logic [7:0]  rx_byte     = 8'h00;
    logic [2:0]  adc_channel = 3'd0;
    logic [15:0] adc_value   = 16'h0000;
    logic [15:0] pin_levels  = 16'h0000;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [15:0] drive_levels;
    logic [15:0] drive_enable;
    logic [15:0] accepted_frames;

    int errors;
    int outstanding;
    int bytes_checked;
    int replies_checked;
    int items_sent  = 0;
    int frames_sent = 0;
    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;

    uart_command_frame_handler dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .rx_byte         (rx_byte),
        .adc_channel     (adc_channel),
        .adc_value       (adc_value),
        .pin_levels      (pin_levels),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .tx_byte         (tx_byte),
        .tx_last         (tx_last),
        .drive_levels    (drive_levels),
        .drive_enable    (drive_enable),
        .accepted_frames (accepted_frames)
    );

    ucfh_reply_monitor monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .rx_byte         (rx_byte),
        .adc_channel     (adc_channel),
        .adc_value       (adc_value),
        .pin_levels      (pin_levels),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .tx_byte         (tx_byte),
        .tx_last         (tx_last),
        .drive_levels    (drive_levels),
        .drive_enable    (drive_enable),
        .accepted_frames (accepted_frames),
        .errors          (errors),
        .outstanding     (outstanding),
        .bytes_checked   (bytes_checked),
        .replies_checked (replies_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hold off the output for a long stretch when asked, else idle at random unless quiet
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                out_ready <= 1'b1;
                wait (!hold_req);
            end
            else
                out_ready <= quiet || ($urandom_range(99) >= 30);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_item(input logic o, input logic [7:0] b, input logic [2:0] ch,
                             input logic [15:0] v, input logic [15:0] pins);
        if (!quiet)
            while ($urandom_range(99) < 30)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        op          <= o;
        rx_byte     <= b;
        adc_channel <= ch;
        adc_value   <= v;
        pin_levels  <= pins;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic [15:0] pins);
        send_item(OP_RX, b, 3'($urandom_range(7)), 16'($urandom_range(16'hFFFF)), pins);
    endtask

    task automatic send_adc(input logic [2:0] ch, input logic [15:0] v);
        send_item(OP_ADC, 8'($urandom_range(255)), ch, v, 16'($urandom_range(16'hFFFF)));
    endtask

    task automatic send_frame(input logic [7:0] code, input logic [7:0] p1,
                              input logic [7:0] p2, input logic [7:0] p3,
                              input logic [7:0] p4, input bit bad,
                              input logic [15:0] pins, input bit mix);
        logic [7:0] frame [8];
        frame[0] = START_A;
        frame[1] = START_B;
        frame[2] = code;
        frame[3] = p1;
        frame[4] = p2;
        frame[5] = p3;
        frame[6] = p4;
        frame[7] = START_A + START_B + code + p1 + p2 + p3 + p4;
        if (bad)
            frame[7] = frame[7] + 8'($urandom_range(1, 255));
        for (int k = 0; k < 8; k++)
        begin
            if (mix && $urandom_range(99) < 5)
                send_adc(3'($urandom_range(7)), 16'($urandom_range(16'hFFFF)));
            send_byte(frame[k], pins);
        end
        frames_sent++;
    endtask

    task automatic random_frame();
        logic [7:0] code;
        logic [7:0] idx;
        logic [7:0] lvl;
        case ($urandom_range(9))
            0:       code = CODE_NOP;
            1, 2:    code = CODE_SET_PIN;
            3:       code = CODE_PONG;
            4, 5:    code = CODE_READ_PIN;
            6, 7:    code = CODE_READ_ADC;
            default: code = 8'($urandom_range(255));
        endcase
        idx = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(17));
        lvl = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255));
        send_frame(code, idx, lvl, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   $urandom_range(99) < 10, 16'($urandom_range(16'hFFFF)), 1'b1);
    endtask

    initial
    begin
        int iter;
        int r;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_adc(3'd0, 16'hFFFF);
        send_item(OP_ADC, START_A, 3'd7, 16'h8001, 16'h0000);
        send_frame(CODE_PONG, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 1'b0);
        send_frame(CODE_SET_PIN, 8'd15, 8'hFF, 8'h00, 8'h00, 1'b0, 16'hFFFF, 1'b0);
        send_frame(CODE_SET_PIN, 8'd0, 8'h00, 8'hFF, 8'hFF, 1'b0, 16'h0000, 1'b0);
        send_frame(CODE_SET_PIN, 8'd16, 8'h01, 8'h00, 8'h00, 1'b0, 16'h0000, 1'b0);
        send_frame(CODE_READ_PIN, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0, 16'hFFFF, 1'b0);
        send_frame(CODE_READ_PIN, 8'd15, 8'h55, 8'hAA, 8'h00, 1'b0, 16'h7FFF, 1'b0);
        send_frame(CODE_READ_PIN, 8'd8, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0100, 1'b0);
        send_frame(CODE_READ_PIN, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 16'hFFFF, 1'b0);
        send_frame(CODE_READ_ADC, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 1'b0);
        send_frame(CODE_READ_ADC, 8'd7, 8'hFF, 8'hFF, 8'hFF, 1'b0, 16'h0000, 1'b0);
        send_frame(CODE_READ_ADC, 8'd8, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 1'b0);
        send_frame(CODE_NOP, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 1'b0);
        send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 16'hFFFF, 1'b0);
        send_frame(CODE_PONG, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 16'h0000, 1'b0);
        send_byte(START_A, 16'h0000);
        send_byte(START_A, 16'h0000);
        send_byte(START_B, 16'h0000);
        send_frame(CODE_PONG, START_A, START_B, START_A, START_B, 1'b0, 16'h0000, 1'b0);
        send_frame(CODE_READ_ADC, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 1'b1);

        iter = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (iter == 6)
                quiet = 1'b1;
            if (iter == 18)
                quiet = 1'b0;
            if (iter == 8)
            begin
                in_valid <= 1'b0;
                wait (outstanding == 0);
                @(negedge clk);
            end
            if (iter == 12)
            begin
                hold_req = 1'b1;
                repeat (4)
                    send_frame(CODE_PONG, 8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0,
                               16'($urandom_range(16'hFFFF)), 1'b0);
                hold_req = 1'b0;
            end
            r = $urandom_range(99);
            if (r < 8)
                send_byte(8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)));
            else if (r < 16)
                send_adc(3'($urandom_range(7)), 16'($urandom_range(16'hFFFF)));
            else if (r < 20)
            begin
                send_byte(START_A, 16'($urandom_range(16'hFFFF)));
                send_byte($urandom_range(1) ? START_A : 8'($urandom_range(255)),
                          16'($urandom_range(16'hFFFF)));
            end
            else
                random_frame();
            iter++;
        end
        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (20) @(posedge clk);

        $display("Sent %0d items in %0d frames plus noise and ADC updates; checked %0d reply bytes",
                 items_sent, frames_sent, bytes_checked);
        $display("in %0d replies, with an output hold-off that stalled the input and a drain pause",
                 replies_checked);
        if (errors == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
